[hw/rtl/adc_wc_pkg.sv]
// ----------------------------------------------------------------------------
// adc_wc_pkg
// Shared types and constants of the ADC window comparator block.
// ----------------------------------------------------------------------------
package adc_wc_pkg;

	localparam int NUM_CH    = 4;
	localparam int CH_IDX_W  = 2;
	localparam int VOLT_W    = 16;
	localparam int CNT_W     = 12;
	localparam int STAT_W    = 2 * NUM_CH;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 2 * CNT_W;
	localparam int CLAMP_W   = 15;
	localparam int MUL_W     = 14;
	localparam int PROD_W    = CLAMP_W + MUL_W;

	// 1.8 V in units of 2^-14 V
	localparam logic [CLAMP_W-1:0] V_MAX_UNITS = 15'd29491;
	// 4095 / 1.8 scaled by 2^-14 and 2^16
	localparam logic [MUL_W-1:0]   CONV_MUL    = 14'd9100;
	// one half in the 2^16 fraction
	localparam logic [PROD_W-1:0]  CONV_ROUND  = 29'd32768;
	localparam logic [CNT_W-1:0]   COUNT_MAX   = 12'd4095;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIN0   = 3'd0,
		REG_WIN1   = 3'd1,
		REG_WIN2   = 3'd2,
		REG_WIN3   = 3'd3,
		REG_IRQ_EN = 3'd4
	} reg_idx_t;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_CLEAR  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [NUM_CH-1:0][CNT_W-1:0] win_hi;
		logic [NUM_CH-1:0][CNT_W-1:0] win_lo;
		logic [STAT_W-1:0]            irq_en;
	} cfg_t;

	typedef struct packed {
		logic [STAT_W-1:0] live;
		logic [STAT_W-1:0] latched;
		logic [STAT_W-1:0] newly;
	} status_t;

endpackage

[hw/rtl/adc_wc_cfg.sv]
// ----------------------------------------------------------------------------
// adc_wc_cfg
// Threshold and enable registers; flags a window write that clears the latch.
// ----------------------------------------------------------------------------
module adc_wc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [adc_wc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [adc_wc_pkg::CFG_W-1:0]      cfg_data,
	output adc_wc_pkg::cfg_t                  cfg,
	output logic                              win_clr
);
	import adc_wc_pkg::*;

	logic [NUM_CH-1:0][CNT_W-1:0] win_hi_q;
	logic [NUM_CH-1:0][CNT_W-1:0] win_lo_q;
	logic [STAT_W-1:0]            irq_en_q;
	logic [CNT_W-1:0]             wr_hi;
	logic [CNT_W-1:0]             wr_lo;
	logic                         win_sel;
	logic                         en_sel;

	assign wr_hi = cfg_data[CFG_W-1:CNT_W];
	assign wr_lo = cfg_data[CNT_W-1:0];

	always_comb begin
		win_sel = 1'b0;
		en_sel  = 1'b0;
		unique case (cfg_index)
			REG_WIN0, REG_WIN1, REG_WIN2, REG_WIN3: win_sel = 1'b1;
			REG_IRQ_EN:                             en_sel  = 1'b1;
			default: ;
		endcase
	end

	// drop inverted windows entirely
	assign win_clr = cfg_we && win_sel && (wr_hi >= wr_lo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_hi_q <= '0;
			win_lo_q <= '0;
			irq_en_q <= '0;
		end else begin
			if (win_clr) begin
				win_hi_q[cfg_index[CH_IDX_W-1:0]] <= wr_hi;
				win_lo_q[cfg_index[CH_IDX_W-1:0]] <= wr_lo;
			end
			if (cfg_we && en_sel) begin
				irq_en_q <= cfg_data[STAT_W-1:0];
			end
		end
	end

	assign cfg.win_hi = win_hi_q;
	assign cfg.win_lo = win_lo_q;
	assign cfg.irq_en = irq_en_q;

endmodule

[hw/rtl/adc_wc_chan.sv]
// ----------------------------------------------------------------------------
// adc_wc_chan
// One channel: clamp the pin voltage, scale to counts, compare with window.
// ----------------------------------------------------------------------------
module adc_wc_chan (
	input  logic signed [adc_wc_pkg::VOLT_W-1:0] voltage,
	input  logic [adc_wc_pkg::CNT_W-1:0]         win_hi,
	input  logic [adc_wc_pkg::CNT_W-1:0]         win_lo,
	output logic [adc_wc_pkg::CNT_W-1:0]         counts,
	output logic                                 below,
	output logic                                 above
);
	import adc_wc_pkg::*;

	logic [CLAMP_W-1:0] v_clamp;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  rounded;
	logic [PROD_W-17:0] scaled;

	always_comb begin
		priority if (voltage[VOLT_W-1]) begin
			v_clamp = '0;
		end else if (voltage[VOLT_W-2:0] > V_MAX_UNITS) begin
			v_clamp = V_MAX_UNITS;
		end else begin
			v_clamp = voltage[VOLT_W-2:0];
		end
	end

	assign prod    = PROD_W'(v_clamp) * PROD_W'(CONV_MUL);
	assign rounded = prod + CONV_ROUND;
	assign scaled  = rounded[PROD_W-1:16];
	assign counts  = (scaled > (PROD_W-16)'(COUNT_MAX)) ? COUNT_MAX : scaled[CNT_W-1:0];

	assign below = counts < win_lo;
	assign above = counts > win_hi;

endmodule

[hw/rtl/adc_wc_status.sv]
// ----------------------------------------------------------------------------
// adc_wc_status
// Live comparator status and the sticky interrupt latch.
// ----------------------------------------------------------------------------
module adc_wc_status (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              clear_item,
	input  logic                              win_clr,
	input  logic [adc_wc_pkg::STAT_W-1:0]     live_in,
	input  logic [adc_wc_pkg::STAT_W-1:0]     irq_en,
	output adc_wc_pkg::status_t               res
);
	import adc_wc_pkg::*;

	logic [STAT_W-1:0] live_q;
	logic [STAT_W-1:0] sticky_q;

	always_comb begin
		if (clear_item) begin
			res.live    = live_q;
			res.latched = '0;
			res.newly   = '0;
		end else begin
			res.live    = live_in;
			res.latched = sticky_q | (live_in & irq_en);
			res.newly   = res.latched & ~sticky_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q   <= '0;
			sticky_q <= '0;
		end else if (win_clr) begin
			sticky_q <= '0;
		end else if (step) begin
			sticky_q <= res.latched;
			live_q   <= res.live;
		end
	end

	as_win_clr_empties: assert property (@(posedge clk) disable iff (!arst_n)
		win_clr |=> sticky_q == '0)
		else $error("latch not cleared by window write");

	as_clear_item_empties: assert property (@(posedge clk) disable iff (!arst_n)
		step && clear_item && !win_clr |=> sticky_q == '0)
		else $error("latch not cleared by clear item");

	as_live_held_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && clear_item && !win_clr |=> $stable(live_q))
		else $error("live status changed on clear item");

endmodule

[hw/rtl/adc_window_comparator_irq.sv]
// ----------------------------------------------------------------------------
// adc_window_comparator_irq
// Four-channel ADC conversion with window comparators and sticky interrupt.
// ----------------------------------------------------------------------------
// Each accepted word is either a sample (kind 0) carrying four signed pin
// voltages in units of 2^-14 V, or a clear (kind 1) that empties the latched
// interrupt status. A sample is clamped to 0..1.8 V, scaled to 12-bit counts
// with rounding, compared against each channel's low/high window, and the
// enabled comparator bits are ORed into the sticky latch; the channel 0
// fault outputs pulse on a newly latched bit. Every word yields exactly one
// result word. The block takes one word per clock while out_stall stays low:
// a word is captured in the input register, the conversion, compare and
// latch update run in one pass of logic, and the result register holds the
// answer, so out_valid rises when the word moves from the input register
// into the result register, and the throughput is one word per cycle while
// out_stall stays low. in_stall rises only when a word waits in the input
// register and the result register is still held by out_stall.
// Write configuration only while idle; a valid window write (high >= low)
// also clears the latch, an inverted window write is ignored, and an
// irq_enable write leaves the latch alone.
// ----------------------------------------------------------------------------
module adc_window_comparator_irq (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [adc_wc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [adc_wc_pkg::CFG_W-1:0]        cfg_data,
	// input words
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic signed [adc_wc_pkg::VOLT_W-1:0] ch0_voltage,
	input  logic signed [adc_wc_pkg::VOLT_W-1:0] ch1_voltage,
	input  logic signed [adc_wc_pkg::VOLT_W-1:0] ch2_voltage,
	input  logic signed [adc_wc_pkg::VOLT_W-1:0] ch3_voltage,
	// result words
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [adc_wc_pkg::CNT_W-1:0]        ch0_counts,
	output logic [adc_wc_pkg::CNT_W-1:0]        ch1_counts,
	output logic [adc_wc_pkg::CNT_W-1:0]        ch2_counts,
	output logic [adc_wc_pkg::CNT_W-1:0]        ch3_counts,
	output logic [adc_wc_pkg::STAT_W-1:0]       live_window_status,
	output logic [adc_wc_pkg::STAT_W-1:0]       latched_irq_status,
	output logic                                overvoltage_fault,
	output logic                                undervoltage_fault
);
	import adc_wc_pkg::*;

	cfg_t                                cfg;
	logic                                win_clr;
	status_t                             stat;

	// input register
	logic                                valid_s1;
	logic                                kind_s1;
	logic signed [NUM_CH-1:0][VOLT_W-1:0] volt_s1;

	// result register
	logic                                valid_s2;
	logic [NUM_CH-1:0][CNT_W-1:0]        counts_s2;
	logic [STAT_W-1:0]                   live_s2;
	logic [STAT_W-1:0]                   latched_s2;
	logic                                ov_s2;
	logic                                uv_s2;

	logic [NUM_CH-1:0][CNT_W-1:0]        counts_c;
	logic [NUM_CH-1:0]                   below_c;
	logic [NUM_CH-1:0]                   above_c;
	logic                                clear_s1;
	logic                                adv_s1;
	logic                                in_take;

	assign clear_s1 = (kind_s1 == KIND_CLEAR);

	// advance stage 1 when the result register is free or being drained
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	adc_wc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.win_clr   (win_clr)
	);

	for (genvar g = 0; g < NUM_CH; g++) begin : g_chan
		adc_wc_chan u_chan (
			.voltage (volt_s1[g]),
			.win_hi  (cfg.win_hi[g]),
			.win_lo  (cfg.win_lo[g]),
			.counts  (counts_c[g]),
			.below   (below_c[g]),
			.above   (above_c[g])
		);
	end

	adc_wc_status u_status (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.clear_item (clear_s1),
		.win_clr    (win_clr),
		.live_in    ({above_c, below_c}),
		.irq_en     (cfg.irq_en),
		.res        (stat)
	);

	// control: valid bits of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload: capture input word
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1    <= kind;
			volt_s1[0] <= ch0_voltage;
			volt_s1[1] <= ch1_voltage;
			volt_s1[2] <= ch2_voltage;
			volt_s1[3] <= ch3_voltage;
		end
	end

	// payload: capture result word; clear words report zero counts
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			counts_s2  <= clear_s1 ? '0 : counts_c;
			live_s2    <= stat.live;
			latched_s2 <= stat.latched;
			ov_s2      <= stat.newly[NUM_CH];
			uv_s2      <= stat.newly[0];
		end
	end

	assign out_valid          = valid_s2;
	assign ch0_counts         = counts_s2[0];
	assign ch1_counts         = counts_s2[1];
	assign ch2_counts         = counts_s2[2];
	assign ch3_counts         = counts_s2[3];
	assign live_window_status = live_s2;
	assign latched_irq_status = latched_s2;
	assign overvoltage_fault  = ov_s2;
	assign undervoltage_fault = uv_s2;

	as_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with nothing waiting");

	as_fault_latched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (overvoltage_fault || undervoltage_fault) |->
		(!overvoltage_fault || latched_irq_status[NUM_CH]) &&
		(!undervoltage_fault || latched_irq_status[0]))
		else $error("fault pulse without latched bit");

	as_window_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (live_window_status[NUM_CH-1:0] &
			live_window_status[STAT_W-1:NUM_CH]) == '0)
		else $error("channel both below and above window");

	as_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && clear_s1 |=> latched_irq_status == '0 && ch0_counts == '0)
		else $error("clear word result not zero");

endmodule
